// ===== rtl/rtdb_pkg.sv =====
// ----------------------------------------------------------------------------
// RMS to dB bar height package
// Shared widths, constants, register indexes and the queue item type.
// ----------------------------------------------------------------------------
package rtdb_pkg;

   localparam int SUM_W  = 56;
   localparam int CNT_W  = 24;
   localparam int HGT_W  = 12;
   localparam int DB_W   = 9;
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam int QUO_W      = 84;
   localparam int SUM_SHIFT  = 28;
   localparam int CHUNK_W    = 28;
   localparam int CHUNKS     = 3;
   localparam int POS_W      = 5;
   localparam int P_W        = 7;
   localparam int MANT_W     = 31;
   localparam int FRAC_W     = 16;
   localparam int LOG_OFFSET = 60;
   localparam int L2_W       = P_W + 1 + FRAC_W;
   localparam int PROD_W     = 51;
   localparam int DBQ_W      = 27;
   localparam int K_SHIFT    = 24;
   localparam int DIFF_W     = 25;
   localparam int N_W        = DIFF_W + HGT_W;
   localparam int NUM_W      = N_W - FRAC_W;
   localparam int DIV_W      = 9;

   localparam logic [26:0] DB_K = 27'd50504453;

   localparam logic signed [DB_W-1:0] DB_FLOOR_RESET   = -9'sd60;
   localparam logic signed [DB_W-1:0] DB_CEILING_RESET = 9'sd0;
   localparam logic [HGT_W-1:0]       MAX_HEIGHT_RESET = 12'd64;
   localparam logic [HGT_W-1:0]       MIN_HEIGHT       = 12'd2;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      REG_DB_FLOOR   = 2'd0,
      REG_DB_CEILING = 2'd1,
      REG_MAX_HEIGHT = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] cnt;
      logic             zero;
   } item_type;

endpackage

// ===== rtl/rtdb_front.sv =====
// ----------------------------------------------------------------------------
// RMS to dB bar height front end
// Accepts bars, flags those whose height is zero and queues them for the back.
// ----------------------------------------------------------------------------
module rtdb_front #(
   parameter int QUEUE_DEPTH = rtdb_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic [rtdb_pkg::SUM_W-1:0]           req_sum_squares,
   input  logic [rtdb_pkg::CNT_W-1:0]           req_sample_count,
   input  logic signed [rtdb_pkg::DB_W-1:0]     db_floor,
   input  logic signed [rtdb_pkg::DB_W-1:0]     db_ceiling,
   input  logic [rtdb_pkg::HGT_W-1:0]           max_height,
   output logic                                 q_valid,
   output rtdb_pkg::item_type                   q_item,
   input  logic                                 q_ready
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rtdb_pkg::item_type mem [QUEUE_DEPTH];
   rtdb_pkg::item_type item;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               wr_en, rd_en;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = mem[rd_ptr_ff];
   assign wr_en   = push && !full;
   assign rd_en   = q_valid && q_ready;

   always_comb begin
      item.sum  = req_sum_squares;
      item.cnt  = req_sample_count;
      item.zero = (req_sample_count == '0) || (db_ceiling <= db_floor) || (max_height == '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== rtl/rtdb_back.sv =====
// ----------------------------------------------------------------------------
// RMS to dB bar height back end
// Pipelined mean-square divider, log2, dB scaling, clip and height divider.
// ----------------------------------------------------------------------------
module rtdb_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  rtdb_pkg::item_type                   q_item,
   output logic                                 q_ready,
   input  logic signed [rtdb_pkg::DB_W-1:0]     db_floor,
   input  logic signed [rtdb_pkg::DB_W-1:0]     db_ceiling,
   input  logic [rtdb_pkg::HGT_W-1:0]           max_height,
   input  logic                                 pop,
   output logic                                 empty,
   output logic [rtdb_pkg::HGT_W-1:0]           rsp_bar_height
);

   localparam int QW  = rtdb_pkg::QUO_W;
   localparam int SQN = rtdb_pkg::FRAC_W;
   localparam int HDN = rtdb_pkg::NUM_W;

   logic en;

   // Mean-square divider.
   logic [QW:0]                  dv_v_ff, dv_v_in, dv_z_ff, dv_z_in;
   logic [rtdb_pkg::SUM_W-1:0]   dv_sum_ff [QW+1];
   logic [rtdb_pkg::SUM_W-1:0]   dv_sum_in [QW+1];
   logic [rtdb_pkg::CNT_W-1:0]   dv_cnt_ff [QW+1];
   logic [rtdb_pkg::CNT_W-1:0]   dv_cnt_in [QW+1];
   logic [rtdb_pkg::CNT_W-1:0]   dv_r_ff [QW+1];
   logic [rtdb_pkg::CNT_W-1:0]   dv_r_in [QW+1];
   logic [QW-1:0]                dv_q_ff [QW+1];
   logic [QW-1:0]                dv_q_in [QW+1];

   // Leading-one search.
   logic                         la_v_ff, la_z_ff, la_s_ff, la_s_in;
   logic [QW-1:0]                la_q_ff;
   logic [rtdb_pkg::CHUNKS-1:0]  la_nz_ff, la_nz_in;
   logic [rtdb_pkg::POS_W-1:0]   la_pos_ff [rtdb_pkg::CHUNKS];
   logic [rtdb_pkg::POS_W-1:0]   la_pos_in [rtdb_pkg::CHUNKS];

   // Fraction by repeated squaring.
   logic [SQN:0]                 sq_v_ff, sq_v_in, sq_z_ff, sq_z_in, sq_s_ff, sq_s_in;
   logic [rtdb_pkg::MANT_W-1:0]  sq_m_ff [SQN+1];
   logic [rtdb_pkg::MANT_W-1:0]  sq_m_in [SQN+1];
   logic [rtdb_pkg::FRAC_W-1:0]  sq_f_ff [SQN+1];
   logic [rtdb_pkg::FRAC_W-1:0]  sq_f_in [SQN+1];
   logic [rtdb_pkg::P_W-1:0]     sq_p_ff [SQN+1];
   logic [rtdb_pkg::P_W-1:0]     sq_p_in [SQN+1];

   // Level, clip and height.
   logic                                 lv_v_ff, lv_z_ff, lv_s_ff;
   logic signed [rtdb_pkg::PROD_W-1:0]   lv_prod_ff, lv_prod_in;
   logic                                 cl_v_ff, cl_z_ff;
   logic [rtdb_pkg::DIFF_W-1:0]          cl_diff_ff, cl_diff_in;
   logic [rtdb_pkg::DIV_W-1:0]           divisor;

   logic [HDN:0]                 hd_v_ff, hd_v_in, hd_z_ff, hd_z_in;
   logic [HDN-1:0]               hd_num_ff [HDN+1];
   logic [HDN-1:0]               hd_num_in [HDN+1];
   logic [rtdb_pkg::DIV_W-1:0]   hd_r_ff [HDN+1];
   logic [rtdb_pkg::DIV_W-1:0]   hd_r_in [HDN+1];
   logic [HDN-1:0]               hd_q_ff [HDN+1];
   logic [HDN-1:0]               hd_q_in [HDN+1];

   logic                         out_v_ff;
   logic [rtdb_pkg::HGT_W-1:0]   out_h_ff, out_h_in;

   assign en             = !out_v_ff || pop;
   assign q_ready        = en;
   assign empty          = !out_v_ff;
   assign rsp_bar_height = out_h_ff;

   always_comb begin
      logic [rtdb_pkg::CNT_W:0] trial;
      logic                     ge;
      int                       k;
      int                       idx;
      dv_v_in[0]   = q_valid;
      dv_z_in[0]   = q_item.zero;
      dv_sum_in[0] = q_item.sum;
      dv_cnt_in[0] = q_item.cnt;
      dv_r_in[0]   = '0;
      dv_q_in[0]   = '0;
      for (int s = 0; s < QW; s++) begin
         k   = QW - 1 - s;
         idx = (k >= rtdb_pkg::SUM_SHIFT) ? k - rtdb_pkg::SUM_SHIFT : 0;
         trial = {dv_r_ff[s],
                  (k >= rtdb_pkg::SUM_SHIFT) ? dv_sum_ff[s][idx] : 1'b0};
         ge    = (trial >= {1'b0, dv_cnt_ff[s]});
         if (ge) begin
            trial = trial - {1'b0, dv_cnt_ff[s]};
         end
         dv_r_in[s+1]   = trial[rtdb_pkg::CNT_W-1:0];
         dv_q_in[s+1]   = {dv_q_ff[s][QW-2:0], ge};
         dv_v_in[s+1]   = dv_v_ff[s];
         dv_z_in[s+1]   = dv_z_ff[s];
         dv_sum_in[s+1] = dv_sum_ff[s];
         dv_cnt_in[s+1] = dv_cnt_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff <= '0;
      end else if (en) begin
         dv_v_ff <= dv_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_z_ff <= dv_z_in;
         for (int s = 0; s <= QW; s++) begin
            dv_sum_ff[s] <= dv_sum_in[s];
            dv_cnt_ff[s] <= dv_cnt_in[s];
            dv_r_ff[s]   <= dv_r_in[s];
            dv_q_ff[s]   <= dv_q_in[s];
         end
      end
   end

   always_comb begin
      la_s_in = (dv_q_ff[QW][QW-1:1] == '0);
      for (int c = 0; c < rtdb_pkg::CHUNKS; c++) begin
         la_nz_in[c]  = |dv_q_ff[QW][c*rtdb_pkg::CHUNK_W +: rtdb_pkg::CHUNK_W];
         la_pos_in[c] = '0;
         for (int j = 0; j < rtdb_pkg::CHUNK_W; j++) begin
            if (dv_q_ff[QW][c*rtdb_pkg::CHUNK_W + j]) begin
               la_pos_in[c] = rtdb_pkg::POS_W'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         la_v_ff <= 1'b0;
      end else if (en) begin
         la_v_ff <= dv_v_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         la_z_ff  <= dv_z_ff[QW];
         la_s_ff  <= la_s_in;
         la_q_ff  <= dv_q_ff[QW];
         la_nz_ff <= la_nz_in;
         for (int c = 0; c < rtdb_pkg::CHUNKS; c++) begin
            la_pos_ff[c] <= la_pos_in[c];
         end
      end
   end

   always_comb begin
      logic [rtdb_pkg::P_W-1:0]       p;
      logic [QW-1:0]                  shifted;
      logic [2*rtdb_pkg::MANT_W-1:0]  prod;
      logic [rtdb_pkg::MANT_W:0]      sqv;
      p = '0;
      for (int c = 0; c < rtdb_pkg::CHUNKS; c++) begin
         if (la_nz_ff[c]) begin
            p = rtdb_pkg::P_W'(c * rtdb_pkg::CHUNK_W) + rtdb_pkg::P_W'(la_pos_ff[c]);
         end
      end
      shifted    = la_q_ff << (rtdb_pkg::P_W'(QW - 1) - p);
      sq_m_in[0] = shifted[QW-1 -: rtdb_pkg::MANT_W];
      sq_f_in[0] = '0;
      sq_p_in[0] = p;
      sq_v_in[0] = la_v_ff;
      sq_z_in[0] = la_z_ff;
      sq_s_in[0] = la_s_ff;
      for (int t = 0; t < SQN; t++) begin
         prod = {{rtdb_pkg::MANT_W{1'b0}}, sq_m_ff[t]} * {{rtdb_pkg::MANT_W{1'b0}}, sq_m_ff[t]};
         sqv  = prod[2*rtdb_pkg::MANT_W-1:rtdb_pkg::MANT_W-1];
         if (sqv[rtdb_pkg::MANT_W]) begin
            sq_m_in[t+1] = sqv[rtdb_pkg::MANT_W:1];
         end else begin
            sq_m_in[t+1] = sqv[rtdb_pkg::MANT_W-1:0];
         end
         sq_f_in[t+1] = {sq_f_ff[t][rtdb_pkg::FRAC_W-2:0], sqv[rtdb_pkg::MANT_W]};
         sq_p_in[t+1] = sq_p_ff[t];
         sq_v_in[t+1] = sq_v_ff[t];
         sq_z_in[t+1] = sq_z_ff[t];
         sq_s_in[t+1] = sq_s_ff[t];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= '0;
      end else if (en) begin
         sq_v_ff <= sq_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_z_ff <= sq_z_in;
         sq_s_ff <= sq_s_in;
         for (int t = 0; t <= SQN; t++) begin
            sq_m_ff[t] <= sq_m_in[t];
            sq_f_ff[t] <= sq_f_in[t];
            sq_p_ff[t] <= sq_p_in[t];
         end
      end
   end

   always_comb begin
      logic signed [rtdb_pkg::P_W:0]    pm;
      logic signed [rtdb_pkg::L2_W-1:0] l2;
      pm = $signed({1'b0, sq_p_ff[SQN]}) - $signed((rtdb_pkg::P_W + 1)'(rtdb_pkg::LOG_OFFSET));
      l2 = $signed({pm, sq_f_ff[SQN]});
      lv_prod_in = rtdb_pkg::PROD_W'(l2) * rtdb_pkg::PROD_W'($signed({1'b0, rtdb_pkg::DB_K}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_v_ff <= 1'b0;
      end else if (en) begin
         lv_v_ff <= sq_v_ff[SQN];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lv_z_ff    <= sq_z_ff[SQN];
         lv_s_ff    <= sq_s_ff[SQN];
         lv_prod_ff <= lv_prod_in;
      end
   end

   always_comb begin
      logic signed [rtdb_pkg::DBQ_W-1:0] db;
      logic signed [rtdb_pkg::DBQ_W-1:0] fq;
      logic signed [rtdb_pkg::DBQ_W-1:0] cq;
      logic signed [rtdb_pkg::DBQ_W-1:0] dd;
      fq = rtdb_pkg::DBQ_W'($signed({db_floor, {rtdb_pkg::FRAC_W{1'b0}}}));
      cq = rtdb_pkg::DBQ_W'($signed({db_ceiling, {rtdb_pkg::FRAC_W{1'b0}}}));
      db = rtdb_pkg::DBQ_W'(lv_prod_ff >>> rtdb_pkg::K_SHIFT);
      if (lv_s_ff || (db < fq)) begin
         db = fq;
      end
      if (db > cq) begin
         db = cq;
      end
      dd         = db - fq;
      cl_diff_in = dd[rtdb_pkg::DIFF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cl_v_ff <= 1'b0;
      end else if (en) begin
         cl_v_ff <= lv_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cl_z_ff    <= lv_z_ff;
         cl_diff_ff <= cl_diff_in;
      end
   end

   always_comb begin
      logic [rtdb_pkg::N_W-1:0]   n;
      logic [rtdb_pkg::DB_W:0]    span;
      logic [rtdb_pkg::DIV_W:0]   trial;
      logic                       ge;
      span    = {db_ceiling[rtdb_pkg::DB_W-1], db_ceiling}
              - {db_floor[rtdb_pkg::DB_W-1], db_floor};
      divisor = span[rtdb_pkg::DIV_W-1:0];
      n       = rtdb_pkg::N_W'(cl_diff_ff) * rtdb_pkg::N_W'(max_height);
      hd_num_in[0] = n[rtdb_pkg::N_W-1:rtdb_pkg::FRAC_W];
      hd_r_in[0]   = '0;
      hd_q_in[0]   = '0;
      hd_v_in[0]   = cl_v_ff;
      hd_z_in[0]   = cl_z_ff;
      for (int s = 0; s < HDN; s++) begin
         trial = {hd_r_ff[s], hd_num_ff[s][HDN-1-s]};
         ge    = (trial >= {1'b0, divisor});
         if (ge) begin
            trial = trial - {1'b0, divisor};
         end
         hd_r_in[s+1]   = trial[rtdb_pkg::DIV_W-1:0];
         hd_q_in[s+1]   = {hd_q_ff[s][HDN-2:0], ge};
         hd_num_in[s+1] = hd_num_ff[s];
         hd_v_in[s+1]   = hd_v_ff[s];
         hd_z_in[s+1]   = hd_z_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hd_v_ff <= '0;
      end else if (en) begin
         hd_v_ff <= hd_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hd_z_ff <= hd_z_in;
         for (int s = 0; s <= HDN; s++) begin
            hd_num_ff[s] <= hd_num_in[s];
            hd_r_ff[s]   <= hd_r_in[s];
            hd_q_ff[s]   <= hd_q_in[s];
         end
      end
   end

   always_comb begin
      logic [rtdb_pkg::HGT_W-1:0] h;
      h = hd_q_ff[HDN][rtdb_pkg::HGT_W-1:0];
      if (hd_z_ff[HDN]) begin
         out_h_in = '0;
      end else if (h < rtdb_pkg::MIN_HEIGHT) begin
         out_h_in = rtdb_pkg::MIN_HEIGHT;
      end else begin
         out_h_in = h;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= hd_v_ff[HDN];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_h_ff <= out_h_in;
      end
   end

endmodule

// ===== rtl/rms_to_db_bar_height_top.sv =====
// ----------------------------------------------------------------------------
// RMS to dB bar height
// Converts a bar's sum of squares and sample count into a display height.
// ----------------------------------------------------------------------------
// A bar enters as a transaction on the request queue (push, full) and its
// height leaves as a transaction on the response queue (empty, pop), one
// height per bar, in order. The user must write the floor, ceiling and
// full-scale height over the APB port only while no bar is in flight; the
// block itself does not enforce this. A bar passes through the input queue,
// the pipelined mean-square divider, the leading-one search, the log2
// squaring chain, dB scaling and clipping, the height multiply and divider
// and one output register, in that order. A new bar is accepted every cycle
// while full is low; the pipeline is fully overlapped.
// When the receiver stops popping, the pipeline holds in place and the input
// queue fills, after which full is raised until results drain.
// Reset empties the queue and pipeline and restores the register defaults.
// ----------------------------------------------------------------------------
module rms_to_db_bar_height_top #(
   parameter int QUEUE_DEPTH = rtdb_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [rtdb_pkg::SUM_W-1:0]         req_sum_squares,
   input  logic [rtdb_pkg::CNT_W-1:0]         req_sample_count,
   output logic                               empty,
   input  logic                               pop,
   output logic [rtdb_pkg::HGT_W-1:0]         rsp_bar_height,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rtdb_pkg::ADDR_W-1:0]        paddr,
   input  logic [rtdb_pkg::DATA_W-1:0]        pwdata,
   output logic [rtdb_pkg::DATA_W-1:0]        prdata,
   output logic                               pready
);

   logic signed [rtdb_pkg::DB_W-1:0] floor_ff, floor_in, ceil_ff, ceil_in;
   logic [rtdb_pkg::HGT_W-1:0]       maxh_ff, maxh_in;
   rtdb_pkg::reg_index_type          reg_index;
   rtdb_pkg::item_type               q_item;
   logic                             q_valid, q_ready, wr_en;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite && pready;
   assign reg_index = rtdb_pkg::reg_index_type'(paddr[3:2]);

   always_comb begin
      floor_in = floor_ff;
      ceil_in  = ceil_ff;
      maxh_in  = maxh_ff;
      if (wr_en) begin
         case (reg_index)
            rtdb_pkg::REG_DB_FLOOR: begin
               floor_in = pwdata[rtdb_pkg::DB_W-1:0];
            end
            rtdb_pkg::REG_DB_CEILING: begin
               ceil_in = pwdata[rtdb_pkg::DB_W-1:0];
            end
            rtdb_pkg::REG_MAX_HEIGHT: begin
               maxh_in = pwdata[rtdb_pkg::HGT_W-1:0];
            end
            default: begin
               maxh_in = maxh_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         rtdb_pkg::REG_DB_FLOOR: begin
            prdata = rtdb_pkg::DATA_W'(floor_ff);
         end
         rtdb_pkg::REG_DB_CEILING: begin
            prdata = rtdb_pkg::DATA_W'(ceil_ff);
         end
         rtdb_pkg::REG_MAX_HEIGHT: begin
            prdata = rtdb_pkg::DATA_W'(maxh_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= rtdb_pkg::DB_FLOOR_RESET;
         ceil_ff  <= rtdb_pkg::DB_CEILING_RESET;
         maxh_ff  <= rtdb_pkg::MAX_HEIGHT_RESET;
      end else begin
         floor_ff <= floor_in;
         ceil_ff  <= ceil_in;
         maxh_ff  <= maxh_in;
      end
   end

   rtdb_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_sum_squares  (req_sum_squares),
      .req_sample_count (req_sample_count),
      .db_floor         (floor_ff),
      .db_ceiling       (ceil_ff),
      .max_height       (maxh_ff),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_ready          (q_ready)
   );

   rtdb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_ready        (q_ready),
      .db_floor       (floor_ff),
      .db_ceiling     (ceil_ff),
      .max_height     (maxh_ff),
      .pop            (pop),
      .empty          (empty),
      .rsp_bar_height (rsp_bar_height)
   );

endmodule
